FILE: hw/rtl/icgr_pkg.sv
// ----------------------------------------------------------------------------
// icgr_pkg
// types and constants shared by the coverage table block
// ----------------------------------------------------------------------------
package icgr_pkg;

    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOGAP = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [3:0]  genome_id;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [31:0] genome_length;
    } t_in_word;

    typedef struct packed {
        logic [31:0] gap_start;
        logic [31:0] gap_end;
        logic [1:0]  status;
        logic        last;
    } t_out_word;

endpackage

FILE: hw/rtl/icgr_if.sv
// ----------------------------------------------------------------------------
// icgr_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
interface icgr_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/icgr_mem.sv
// ----------------------------------------------------------------------------
// icgr_mem
// interval table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module icgr_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);
    logic [63:0] r_mem [DEPTH];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/interval_coalesce_gap_report_top.sv
// ----------------------------------------------------------------------------
// interval_coalesce_gap_report_top
// per-genome sorted coverage tables: merge/insert ranges, report gaps
// ----------------------------------------------------------------------------
// channel   dir  word        handshake
// i_in      in   t_in_word   valid/ready, one item at a time
// o_out     out  t_out_word  valid/ready, one word per add, one or more per report
//
// a new word is taken only once the last result of the previous item has left.
// an add reads the table entry by entry up to the insert point, then, on an
// insert or a both-side merge, moves entries one read and one write apiece.
// a report reads each entry in turn and sends one word per gap found;
// a stalled output holds the walk.
// counts and lengths clear on reset; the table memory is never cleared and only
// entries below a genome's count are read.
module interval_coalesce_gap_report_top #(
    parameter int GENOMES   = 16,
    parameter int INTERVALS = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    icgr_if.sink   i_in,
    icgr_if.source o_out
);
    import icgr_pkg::*;

    localparam int GW = (GENOMES > 1) ? $clog2(GENOMES) : 1;
    localparam int IW = $clog2(INTERVALS);
    localparam int CW = $clog2(INTERVALS + 1);
    localparam int AW = GW + IW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SRCH   = 4'd1;
    localparam logic [3:0] S_SRCHW  = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_DNRD   = 4'd4;
    localparam logic [3:0] S_DNWR   = 4'd5;
    localparam logic [3:0] S_UPRD   = 4'd6;
    localparam logic [3:0] S_UPWR   = 4'd7;
    localparam logic [3:0] S_RPRD   = 4'd8;
    localparam logic [3:0] S_RPW    = 4'd9;
    localparam logic [3:0] S_RPEND  = 4'd10;
    localparam logic [3:0] S_FIX    = 4'd11;

    logic [3:0]    r_st;
    logic [CW-1:0] r_cnt [GENOMES];
    logic [31:0]   r_len [GENOMES];
    logic [GW-1:0] r_g;
    logic [31:0]   r_s, r_e, r_l;
    logic [CW-1:0] r_n, r_i, r_p;
    logic [31:0]   r_pe;            // end of previous entry
    logic          r_first;
    logic          r_dn;            // both-side merge, shift tail down after fix
    logic          r_pv;            // a gap is held back until its successor is known
    logic [31:0]   r_pgs, r_pge;
    t_out_word     r_o;
    logic          r_ov;
    logic [63:0]   r_left;          // entry p-1

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata, rdata;

    icgr_mem #(.DEPTH(1 << AW), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    function automatic logic [AW-1:0] addr(input logic [GW-1:0] g, input logic [CW-1:0] i);
        addr = {g, i[IW-1:0]};
    endfunction

    wire [31:0] rs = rdata[63:32];
    wire [31:0] re = rdata[31:0];
    wire in_ok = (32'(i_in.data.genome_id) < 32'(GENOMES));
    wire left  = (r_p != '0) && ({1'b0, r_left[31:0]} + 33'd1 == {1'b0, r_s});
    wire right = (r_p < r_n) && ({1'b0, r_e} + 33'd1 == {1'b0, rs});
    wire gap_hit = r_first ? (rs > 32'd1) :
                   ((rs != 32'd0) && ({1'b0, r_pe} + 33'd1 <= {1'b0, rs} - 33'd1));
    wire end_hit = r_first ? (r_l != 32'd0) : (r_pe < r_l);

    assign i_in.ready  = (r_st == S_IDLE) && !r_ov;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_o;

    always_comb begin
        we    = 1'b0;
        waddr = addr(r_g, r_i);
        wdata = rdata;
        raddr = addr(r_g, r_i);
        case (r_st)
            S_UPRD: begin raddr = addr(r_g, r_i - 1'b1); end
            S_UPWR: begin we = 1'b1; end
            S_DNRD: begin raddr = addr(r_g, r_i + 1'b1); end
            S_DNWR: begin we = 1'b1; end
            S_FIX:  begin we = 1'b1; waddr = addr(r_g, r_p); wdata = {r_s, r_e}; end
            default: begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
            r_pv <= 1'b0;
            for (int k = 0; k < GENOMES; k++) begin
                r_cnt[k] <= '0;
                r_len[k] <= '0;
            end
        end else begin
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_g <= GW'(i_in.data.genome_id);
                        r_i <= '0;
                        r_first <= 1'b1;
                        r_pv <= 1'b0;
                        r_dn <= 1'b0;
                        if (!in_ok) begin
                            r_o  <= '{32'd0, 32'd0,
                                      (i_in.data.kind == KIND_ADD) ? ST_FULL : ST_NOGAP, 1'b1};
                            r_ov <= 1'b1;
                        end else if (i_in.data.kind == KIND_ADD) begin
                            r_len[GW'(i_in.data.genome_id)] <= i_in.data.genome_length;
                            if (i_in.data.range_start > i_in.data.range_end) begin
                                r_s <= i_in.data.range_end; r_e <= i_in.data.range_start;
                            end else begin
                                r_s <= i_in.data.range_start; r_e <= i_in.data.range_end;
                            end
                            r_n  <= r_cnt[GW'(i_in.data.genome_id)];
                            r_st <= S_SRCH;
                        end else begin
                            r_n  <= r_cnt[GW'(i_in.data.genome_id)];
                            r_l  <= r_len[GW'(i_in.data.genome_id)];
                            r_st <= S_RPRD;
                        end
                    end
                end
                S_SRCH: begin
                    // read issued for entry r_i
                    if (r_i == r_n) begin
                        r_p <= r_n; r_st <= S_DECIDE;
                    end else begin
                        r_st <= S_SRCHW;
                    end
                end
                S_SRCHW: begin
                    if (r_e < rs) begin
                        r_p <= r_i; r_st <= S_DECIDE;
                    end else begin
                        r_left <= rdata; r_i <= r_i + 1'b1; r_st <= S_SRCH;
                    end
                end
                S_DECIDE: begin
                    // rdata is entry p when p < n
                    if (left && right) begin
                        // entry p-1 becomes {start(p-1), end(p)}, rest moves down
                        r_s <= r_left[63:32]; r_e <= re; r_p <= r_p - 1'b1;
                        r_dn <= 1'b1;
                        r_cnt[r_g] <= r_n - 1'b1;
                        r_st <= S_FIX;
                    end else if (right) begin
                        r_e <= re; r_st <= S_FIX;
                    end else if (left) begin
                        r_s <= r_left[63:32]; r_p <= r_p - 1'b1; r_st <= S_FIX;
                    end else if (r_n >= CW'(INTERVALS)) begin
                        r_o <= '{32'd0, 32'd0, ST_FULL, 1'b1}; r_ov <= 1'b1; r_st <= S_IDLE;
                    end else begin
                        r_cnt[r_g] <= r_n + 1'b1;
                        r_i <= r_n;
                        r_st <= S_UPRD;
                    end
                end
                S_UPRD: begin
                    // read entry i-1 for slot i
                    if (r_i == r_p) r_st <= S_FIX;
                    else r_st <= S_UPWR;
                end
                S_UPWR: begin
                    r_i <= r_i - 1'b1; r_st <= S_UPRD;
                end
                S_FIX: begin
                    if (r_dn) begin
                        r_i <= r_p + 1'b1; r_st <= S_DNRD;
                    end else begin
                        r_o <= '{32'd0, 32'd0, ST_OK, 1'b1}; r_ov <= 1'b1; r_st <= S_IDLE;
                    end
                end
                S_DNRD: begin
                    // read entry i+1 for slot i
                    if (r_i + 1'b1 >= r_n) begin
                        r_o <= '{32'd0, 32'd0, ST_OK, 1'b1}; r_ov <= 1'b1; r_st <= S_IDLE;
                    end else begin
                        r_st <= S_DNWR;
                    end
                end
                S_DNWR: begin
                    r_i <= r_i + 1'b1; r_st <= S_DNRD;
                end
                S_RPRD: begin
                    if (!r_ov) begin
                        if (r_i == r_n) r_st <= S_RPEND;
                        else r_st <= S_RPW;
                    end
                end
                S_RPW: begin
                    r_pe <= re; r_first <= 1'b0; r_i <= r_i + 1'b1; r_st <= S_RPRD;
                    if (gap_hit) begin
                        if (r_pv) begin
                            r_o  <= '{r_pgs, r_pge, ST_OK, 1'b0};
                            r_ov <= 1'b1;
                        end
                        r_pgs <= r_first ? 32'd1 : r_pe + 32'd1;
                        r_pge <= rs - 32'd1;
                        r_pv  <= 1'b1;
                    end
                end
                S_RPEND: begin
                    if (!r_ov) begin
                        if (end_hit) begin
                            if (r_pv) begin
                                r_o  <= '{r_pgs, r_pge, ST_OK, 1'b0};
                                r_pv <= 1'b0;
                            end else begin
                                r_o  <= '{r_first ? 32'd1 : r_pe + 32'd1, r_l, ST_OK, 1'b1};
                                r_st <= S_IDLE;
                            end
                        end else if (r_pv) begin
                            r_o  <= '{r_pgs, r_pge, ST_OK, 1'b1};
                            r_pv <= 1'b0;
                            r_st <= S_IDLE;
                        end else begin
                            r_o  <= '{32'd0, 32'd0, ST_NOGAP, 1'b1};
                            r_st <= S_IDLE;
                        end
                        r_ov <= 1'b1;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: dv/tb_interval_coalesce_gap_report_top.sv
// ----------------------------------------------------------------------------
// tb_interval_coalesce_gap_report_top
// drives add and report words into the coverage table block and checks every
// gap and status word against a model of the per-genome range tables
// ----------------------------------------------------------------------------
module tb_interval_coalesce_gap_report_top;
    import icgr_pkg::*;

    localparam int NGEN  = 16;
    localparam int NINT  = 32;
    localparam int LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;

    icgr_if #(.T(t_in_word))  in_ch ();
    icgr_if #(.T(t_out_word)) out_ch ();

    interval_coalesce_gap_report_top #(
        .GENOMES(NGEN),
        .INTERVALS(NINT)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_ch),
        .o_out(out_ch)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // model of the coverage tables
    logic [31:0] cov_lo [NGEN][NINT];
    logic [31:0] cov_hi [NGEN][NINT];
    int          cov_n  [NGEN];
    logic [31:0] gen_len [NGEN];

    t_out_word gap_q [$];
    int        errors;
    int        idle_cycles;
    bit        stim_done;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic void push_word(input logic [31:0] a, input logic [31:0] b,
                                      input logic [1:0] st, input logic lst);
        t_out_word w;
        w.gap_start = a;
        w.gap_end   = b;
        w.status    = st;
        w.last      = lst;
        gap_q = {gap_q, w};
    endfunction

    function automatic logic [1:0] table_add(input int g, input logic [31:0] s0,
                                             input logic [31:0] e0,
                                             input logic [31:0] len);
        logic [31:0] s, e;
        int n, p, i;
        bit lft, rgt;
        n = cov_n[g];
        gen_len[g] = len;
        s = (s0 > e0) ? e0 : s0;
        e = (s0 > e0) ? s0 : e0;
        p = n;
        for (i = 0; i < n; i++) begin
            if (e < cov_lo[g][i]) begin
                p = i;
                break;
            end
        end
        lft = (p > 0) && ({1'b0, cov_hi[g][p-1]} + 33'd1 == {1'b0, s});
        rgt = (p < n) && ({1'b0, e} + 33'd1 == {1'b0, cov_lo[g][p]});
        if (lft && rgt) begin
            cov_lo[g][p] = cov_lo[g][p-1];
            for (i = p - 1; i + 1 < n; i++) begin
                cov_lo[g][i] = cov_lo[g][i+1];
                cov_hi[g][i] = cov_hi[g][i+1];
            end
            cov_n[g] = n - 1;
            return ST_OK;
        end
        if (rgt) begin
            cov_lo[g][p] = s;
            return ST_OK;
        end
        if (lft) begin
            cov_hi[g][p-1] = e;
            return ST_OK;
        end
        if (n >= NINT) return ST_FULL;
        for (i = n; i > p; i--) begin
            cov_lo[g][i] = cov_lo[g][i-1];
            cov_hi[g][i] = cov_hi[g][i-1];
        end
        cov_lo[g][p] = s;
        cov_hi[g][p] = e;
        cov_n[g] = n + 1;
        return ST_OK;
    endfunction

    function automatic void gap_if_ok(inout t_out_word gl [$], input logic [32:0] a,
                                      input logic [32:0] b);
        t_out_word w;
        if (a >= 1 && a <= b && b <= 33'hFFFF_FFFF) begin
            w.gap_start = a[31:0];
            w.gap_end   = b[31:0];
            w.status    = ST_OK;
            w.last      = 1'b0;
            gl = {gl, w};
        end
    endfunction

    function automatic void predict_word(input t_in_word w);
        t_out_word gl [$];
        int g, n, i;
        g = w.genome_id;
        if (w.kind == KIND_ADD) begin
            push_word('0, '0, table_add(g, w.range_start, w.range_end,
                      w.genome_length), 1'b1);
            return;
        end
        n = cov_n[g];
        if (n == 0) begin
            gap_if_ok(gl, 33'd1, {1'b0, gen_len[g]});
        end else begin
            if (cov_lo[g][0] > 1) gap_if_ok(gl, 33'd1, {1'b0, cov_lo[g][0]} - 33'd1);
            for (i = 1; i < n; i++)
                if (cov_lo[g][i] > 0)
                    gap_if_ok(gl, {1'b0, cov_hi[g][i-1]} + 33'd1,
                              {1'b0, cov_lo[g][i]} - 33'd1);
            if (cov_hi[g][n-1] < gen_len[g])
                gap_if_ok(gl, {1'b0, cov_hi[g][n-1]} + 33'd1, {1'b0, gen_len[g]});
        end
        if (gl.size() == 0) begin
            push_word('0, '0, ST_NOGAP, 1'b1);
            return;
        end
        gl[gl.size()-1].last = 1'b1;
        gap_q = {gap_q, gl};
    endfunction

    // directed rows: typed result used where ck is set (single word items)
    typedef struct {
        logic        kind;
        logic [3:0]  gid;
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] len;
        bit          ck;
        logic [1:0]  st;
    } t_row;

    t_row rows [] = '{
        '{KIND_REPORT, 4'd0, 0, 0, 0, 1, ST_NOGAP},          // empty, zero size
        '{KIND_ADD, 4'd0, 32'd10, 32'd20, 32'd100, 1, ST_OK},
        '{KIND_ADD, 4'd0, 32'd30, 32'd21, 32'd100, 1, ST_OK}, // reversed, left merge
        '{KIND_ADD, 4'd0, 32'd50, 32'd60, 32'd100, 1, ST_OK},
        '{KIND_ADD, 4'd0, 32'd40, 32'd49, 32'd100, 1, ST_OK}, // right merge
        '{KIND_ADD, 4'd0, 32'd31, 32'd39, 32'd100, 1, ST_OK}, // both sides
        '{KIND_REPORT, 4'd0, 0, 0, 0, 0, ST_OK},
        '{KIND_ADD, 4'd0, 32'd1, 32'd5, 32'd100, 1, ST_OK},
        '{KIND_ADD, 4'd0, 32'd3, 32'd70, 32'd100, 1, ST_OK},  // overlapping
        '{KIND_REPORT, 4'd0, 0, 0, 0, 0, ST_OK},
        '{KIND_ADD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK},
        '{KIND_ADD, 4'd15, 32'h1, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, ST_OK},
        '{KIND_REPORT, 4'd15, 0, 0, 0, 1, ST_NOGAP},
        '{KIND_ADD, 4'd7, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'h5, 1, ST_OK},
        '{KIND_REPORT, 4'd7, 0, 0, 0, 0, ST_OK},
        '{KIND_ADD, 4'd8, 32'd1, 32'd1, 32'd1, 1, ST_OK},
        '{KIND_REPORT, 4'd8, 0, 0, 0, 1, ST_NOGAP},
        '{KIND_REPORT, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, ST_OK}
    };

    task automatic send_word(input t_in_word w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_word(w);
        @(negedge i_clk);
    endtask

    task automatic send_rand(input int g, input bit add, input bit wide);
        t_in_word w;
        logic [31:0] base;
        w.kind = add ? KIND_ADD : KIND_REPORT;
        w.genome_id = g[3:0];
        base = $urandom_range(1, 2000);
        if (wide) begin
            w.range_start = $urandom();
            w.range_end   = $urandom();
            w.genome_length = $urandom();
        end else begin
            // pick start next to an existing edge often, to get merges
            if (cov_n[g] > 0 && $urandom_range(0, 1)) begin
                int j;
                j = $urandom_range(0, cov_n[g] - 1);
                base = $urandom_range(0, 1) ? cov_hi[g][j] + 1 : cov_lo[g][j];
            end
            w.range_start = base;
            w.range_end   = base + $urandom_range(0, 20);
            if ($urandom_range(0, 7) == 0) w.range_start = w.range_end + 3;
            w.genome_length = $urandom_range(1, 2600);
        end
        if (w.range_start == 0) w.range_start = 1;
        if (w.range_end == 0) w.range_end = 1;
        if (w.genome_length == 0) w.genome_length = 1;
        send_word(w);
    endtask

    initial begin
        t_in_word w;
        int g;
        errors = 0;
        stim_done = 0;
        for (int i = 0; i < NGEN; i++) begin
            cov_n[i] = 0;
            gen_len[i] = '0;
        end
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[r]) begin
            w.kind = rows[r].kind;
            w.genome_id = rows[r].gid;
            w.range_start = rows[r].s;
            w.range_end = rows[r].e;
            w.genome_length = rows[r].len;
            send_word(w);
            if (rows[r].ck && gap_q.size() > 0 && gap_q[$].status != rows[r].st)
                report_mismatch($sformatf("row %0d status %0d typed %0d", r,
                                gap_q[$].status, rows[r].st));
        end
        // fill one table to overflow, with spaced ranges
        for (int i = 0; i < NINT + 2; i++) begin
            w.kind = KIND_ADD;
            w.genome_id = 4'd3;
            w.range_start = 100 * i + 10;
            w.range_end = 100 * i + 20;
            w.genome_length = 32'd5000;
            send_word(w);
        end
        if (gap_q[$].status != ST_FULL) report_mismatch("full table not flagged");
        send_rand(3, 0, 0);
        // random part, mostly small ranges in a few genomes
        for (int i = 0; i < 90; i++) begin
            g = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(4, 6);
            send_rand(g, $urandom_range(0, 3) != 0, $urandom_range(0, 15) == 0);
        end
        for (int i = 0; i < NGEN; i++) send_rand(i, 0, 0);
        in_ch.valid <= 1'b0;
        stim_done = 1;
    end

    // output side
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            int stall;
            @(negedge i_clk);
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_out_word got, want;
            got = out_ch.data;
            if (gap_q.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", got));
            end else begin
                want = gap_q.pop_front();
                if (got.gap_start !== want.gap_start)
                    report_mismatch($sformatf("gap_start %h want %h", got.gap_start,
                                    want.gap_start));
                if (got.gap_end !== want.gap_end)
                    report_mismatch($sformatf("gap_end %h want %h", got.gap_end,
                                    want.gap_end));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", got.status,
                                    want.status));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0d want %0d", got.last, want.last));
            end
        end
    end

    // watchdog and end of run
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (stim_done && gap_q.size() == 0) break;
            if (idle_cycles >= LIMIT) break;
        end
        if (idle_cycles >= LIMIT) begin
            $display("simulation failed");
        end else begin
            repeat (100) @(posedge i_clk);
            if (errors == 0) begin
                $display("simulation ok");
            end else begin
                $display("simulation failed");
            end
        end
        $finish;
    end

endmodule
